// ===== design/lbs_pkg.sv =====
// Shared types and constants for the largest blob selector.
`default_nettype none

package lbs_pkg;

  localparam int unsigned SigW     = 16;
  localparam int unsigned XW       = 9;
  localparam int unsigned YW       = 8;
  localparam int unsigned WW       = 9;
  localparam int unsigned HW       = 8;
  localparam int unsigned AreaW    = 17;
  localparam int unsigned RefW     = 24;
  localparam int unsigned DistW    = 14;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic [DistW-1:0]  DIST_SAT      = 14'd15984;
  localparam logic [SigW-1:0]   SIG_A_RESET   = 16'd1;
  localparam logic [SigW-1:0]   SIG_B_RESET   = 16'd2;
  localparam logic [RefW-1:0]   REF_RESET     = 24'd24000;
  localparam logic [DivCntW-1:0] DIV_LAST_STEP = 5'd23;

  typedef enum logic [1:0] {
    REG_SIG_A = 2'd0,
    REG_SIG_B = 2'd1,
    REG_REF   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [SigW-1:0] sig_a;
    logic [SigW-1:0] sig_b;
    logic [RefW-1:0] ref_product;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== design/largest_blob_select_with_range.sv =====
// Top level: largest matching blob tracker with iterative distance divide.
//
//  channel | handshake                    | word
//  --------+------------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o      | block_valid, signature, pos, box, last
//  out     | out_valid_o / out_stall_i    | detected, best_*, distance_q4
//  cfg     | APB psel/penable/pwrite      | match_sig_a, match_sig_b, ref_product
//
// A word without last_in_frame passes through capture and area compare; a last
// word with a match adds divider start, the 24-step divider and output wait,
// without one only output wait. in_stall_o is high outside the idle state.
// Reset clears the kept block and loads register defaults.
// A stalled result holds until out_stall_i drops.
`default_nettype none

module largest_blob_select_with_range (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lbs_pkg::PaddrW-1:0]    paddr,
  input  wire logic [lbs_pkg::PdataW-1:0]    pwdata,
  output logic      [lbs_pkg::PdataW-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          block_valid_i,
  input  wire logic [lbs_pkg::SigW-1:0]      signature_i,
  input  wire logic [lbs_pkg::XW-1:0]        pos_x_i,
  input  wire logic [lbs_pkg::YW-1:0]        pos_y_i,
  input  wire logic [lbs_pkg::WW-1:0]        box_width_i,
  input  wire logic [lbs_pkg::HW-1:0]        box_height_i,
  input  wire logic                          last_in_frame_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               detected_o,
  output logic      [lbs_pkg::SigW-1:0]      best_signature_o,
  output logic      [lbs_pkg::XW-1:0]        best_x_o,
  output logic      [lbs_pkg::YW-1:0]        best_y_o,
  output logic      [lbs_pkg::WW-1:0]        best_width_o,
  output logic      [lbs_pkg::HW-1:0]        best_height_o,
  output logic      [lbs_pkg::DistW-1:0]     distance_q4_o
);

  lbs_pkg::cfg_t       cfg;
  lbs_pkg::state_e     state_q, state_d;
  lbs_pkg::div_stat_t  div_stat;
  logic [lbs_pkg::RefW-1:0] quotient;
  logic                div_start;

  logic                     it_valid_q, it_last_q;
  logic [lbs_pkg::SigW-1:0] it_sig_q;
  logic [lbs_pkg::XW-1:0]   it_x_q;
  logic [lbs_pkg::YW-1:0]   it_y_q;
  logic [lbs_pkg::WW-1:0]   it_w_q;
  logic [lbs_pkg::HW-1:0]   it_h_q;

  logic [lbs_pkg::AreaW-1:0] best_area_q, area;
  logic                      found_q;
  logic [lbs_pkg::SigW-1:0]  kept_sig_q;
  logic [lbs_pkg::XW-1:0]    kept_x_q;
  logic [lbs_pkg::YW-1:0]    kept_y_q;
  logic [lbs_pkg::WW-1:0]    kept_w_q;
  logic [lbs_pkg::HW-1:0]    kept_h_q;
  logic [lbs_pkg::DistW-1:0] dist_q;
  logic                      take, in_acc, out_acc;

  lbs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg.ref_product),
    .divisor_i  (kept_h_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;
  assign area    = lbs_pkg::AreaW'(it_w_q) * lbs_pkg::AreaW'(it_h_q);
  assign take    = it_valid_q & ((it_sig_q == cfg.sig_a) | (it_sig_q == cfg.sig_b))
                   & (area > best_area_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbs_pkg::ST_IDLE:      if (in_acc) state_d = lbs_pkg::ST_CMP;
      lbs_pkg::ST_CMP: begin
        if (!it_last_q) state_d = lbs_pkg::ST_IDLE;
        else if (take || found_q) state_d = lbs_pkg::ST_DIV_START;
        else state_d = lbs_pkg::ST_OUT;
      end
      lbs_pkg::ST_DIV_START: state_d = lbs_pkg::ST_DIV_WAIT;
      lbs_pkg::ST_DIV_WAIT:  if (div_stat.done) state_d = lbs_pkg::ST_OUT;
      lbs_pkg::ST_OUT:       if (!out_stall_i) state_d = lbs_pkg::ST_IDLE;
      default:               state_d = lbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != lbs_pkg::ST_IDLE);
    out_valid_o = (state_q == lbs_pkg::ST_OUT);
    div_start   = (state_q == lbs_pkg::ST_DIV_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_valid_q <= block_valid_i;
      it_sig_q   <= signature_i;
      it_x_q     <= pos_x_i;
      it_y_q     <= pos_y_i;
      it_w_q     <= box_width_i;
      it_h_q     <= box_height_i;
      it_last_q  <= last_in_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_area_q <= '0;
      found_q     <= 1'b0;
      kept_sig_q  <= '0;
      kept_x_q    <= '0;
      kept_y_q    <= '0;
      kept_w_q    <= '0;
      kept_h_q    <= '0;
      dist_q      <= lbs_pkg::DIST_SAT;
    end else begin
      if (state_q == lbs_pkg::ST_CMP) begin
        if (take) begin
          best_area_q <= area;
          found_q     <= 1'b1;
          kept_sig_q  <= it_sig_q;
          kept_x_q    <= it_x_q;
          kept_y_q    <= it_y_q;
          kept_w_q    <= it_w_q;
          kept_h_q    <= it_h_q;
        end
        dist_q <= lbs_pkg::DIST_SAT;
      end
      if (state_q == lbs_pkg::ST_DIV_WAIT && div_stat.done) begin
        dist_q <= (quotient > lbs_pkg::RefW'(lbs_pkg::DIST_SAT)) ? lbs_pkg::DIST_SAT
                                                                 : quotient[lbs_pkg::DistW-1:0];
      end
      if (out_acc) begin
        best_area_q <= '0;
        found_q     <= 1'b0;
        kept_sig_q  <= '0;
        kept_x_q    <= '0;
        kept_y_q    <= '0;
        kept_w_q    <= '0;
        kept_h_q    <= '0;
      end
    end
  end

  assign detected_o       = found_q;
  assign best_signature_o = kept_sig_q;
  assign best_x_o         = kept_x_q;
  assign best_y_o         = kept_y_q;
  assign best_width_o     = kept_w_q;
  assign best_height_o    = kept_h_q;
  assign distance_q4_o    = dist_q;

  a_div_only_when_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> found_q && kept_h_q != '0)
    else $error("divider started without a kept block");

  a_dist_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_q4_o <= lbs_pkg::DIST_SAT)
    else $error("distance above saturation");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !detected_o |-> best_height_o == '0 && best_width_o == '0
                                   && distance_q4_o == lbs_pkg::DIST_SAT)
    else $error("empty result not cleared");

  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_area_q != '0 && kept_w_q != '0 && kept_h_q != '0)
    else $error("kept block has zero area");

  a_cleared_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !found_q && best_area_q == '0)
    else $error("frame state not cleared after result");

endmodule

`default_nettype wire

// ===== design/lbs_apb_regs.sv =====
// APB configuration registers for the largest blob selector.
`default_nettype none

module lbs_apb_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lbs_pkg::PaddrW-1:0]  paddr,
  input  wire logic [lbs_pkg::PdataW-1:0]  pwdata,
  output logic      [lbs_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  output lbs_pkg::cfg_t                    cfg_o
);

  lbs_pkg::cfg_t      cfg_q;
  lbs_pkg::reg_idx_e  idx;
  logic               wr_en;

  assign idx    = lbs_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sig_a       <= lbs_pkg::SIG_A_RESET;
      cfg_q.sig_b       <= lbs_pkg::SIG_B_RESET;
      cfg_q.ref_product <= lbs_pkg::REF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        lbs_pkg::REG_SIG_A: cfg_q.sig_a       <= pwdata[lbs_pkg::SigW-1:0];
        lbs_pkg::REG_SIG_B: cfg_q.sig_b       <= pwdata[lbs_pkg::SigW-1:0];
        lbs_pkg::REG_REF:   cfg_q.ref_product <= pwdata[lbs_pkg::RefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lbs_pkg::REG_SIG_A: prdata = lbs_pkg::PdataW'(cfg_q.sig_a);
      lbs_pkg::REG_SIG_B: prdata = lbs_pkg::PdataW'(cfg_q.sig_b);
      lbs_pkg::REG_REF:   prdata = lbs_pkg::PdataW'(cfg_q.ref_product);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lbs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module lbs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lbs_pkg::RefW-1:0]   dividend_i,
  input  wire logic [lbs_pkg::HW-1:0]     divisor_i,
  output lbs_pkg::div_stat_t              stat_o,
  output logic      [lbs_pkg::RefW-1:0]   quotient_o
);

  logic [lbs_pkg::HW-1:0]       rem_q;
  logic [lbs_pkg::HW:0]         rem_d;
  logic [lbs_pkg::RefW-1:0]     dvd_q, dvd_d;
  logic [lbs_pkg::HW-1:0]       dvs_q;
  logic [lbs_pkg::DivCntW-1:0]  cnt_q;
  logic                         busy_q, done_q;
  logic [lbs_pkg::HW:0]         trial;
  logic                         ge;

  assign trial = {rem_q, dvd_q[lbs_pkg::RefW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? (trial - {1'b0, dvs_q}) : trial;
  assign dvd_d = {dvd_q[lbs_pkg::RefW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lbs_pkg::DIV_LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d[lbs_pkg::HW-1:0];
      dvd_q <= dvd_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_largest_blob_select_with_range.sv =====
// Testbench for the largest blob selector: directed and random frames against a scoreboard.
`timescale 1ns / 100ps

module tb_largest_blob_select_with_range;

  localparam int unsigned DrainCycles = 64;
  localparam int unsigned ChunkWords  = 210;

  typedef struct packed {
    logic                     block_valid;
    logic [lbs_pkg::SigW-1:0] signature;
    logic [lbs_pkg::XW-1:0]   pos_x;
    logic [lbs_pkg::YW-1:0]   pos_y;
    logic [lbs_pkg::WW-1:0]   box_width;
    logic [lbs_pkg::HW-1:0]   box_height;
    logic                     last_in_frame;
  } blob_word_t;

  typedef struct packed {
    logic                      detected;
    logic [lbs_pkg::SigW-1:0]  signature;
    logic [lbs_pkg::XW-1:0]    x;
    logic [lbs_pkg::YW-1:0]    y;
    logic [lbs_pkg::WW-1:0]    width;
    logic [lbs_pkg::HW-1:0]    height;
    logic [lbs_pkg::DistW-1:0] distance;
  } blob_result_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic [lbs_pkg::PaddrW-1:0] paddr           = '0;
  logic [lbs_pkg::PdataW-1:0] pwdata          = '0;
  logic [lbs_pkg::PdataW-1:0] prdata;
  logic                       pready;
  logic                       in_valid_i      = 1'b0;
  logic                       in_stall_o;
  logic                       block_valid_i   = 1'b0;
  logic [lbs_pkg::SigW-1:0]   signature_i     = '0;
  logic [lbs_pkg::XW-1:0]     pos_x_i         = '0;
  logic [lbs_pkg::YW-1:0]     pos_y_i         = '0;
  logic [lbs_pkg::WW-1:0]     box_width_i     = '0;
  logic [lbs_pkg::HW-1:0]     box_height_i    = '0;
  logic                       last_in_frame_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i     = 1'b0;
  logic                       detected_o;
  logic [lbs_pkg::SigW-1:0]   best_signature_o;
  logic [lbs_pkg::XW-1:0]     best_x_o;
  logic [lbs_pkg::YW-1:0]     best_y_o;
  logic [lbs_pkg::WW-1:0]     best_width_o;
  logic [lbs_pkg::HW-1:0]     best_height_o;
  logic [lbs_pkg::DistW-1:0]  distance_q4_o;

  blob_result_t              expected_blobs[$];
  blob_result_t              want_blob;
  lbs_pkg::cfg_t             cfg_mirror;
  logic [lbs_pkg::AreaW-1:0] best_area;
  logic                      found_blob;
  blob_word_t                kept_blob;
  int unsigned               error_count   = 0;
  int unsigned               words_sent    = 0;
  int unsigned               send_idle_pct = 18;
  int unsigned               recv_idle_pct = 47;
  int unsigned               hold_request  = 0;
  int unsigned               hold_left     = 0;

  largest_blob_select_with_range dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .block_valid_i    (block_valid_i),
    .signature_i      (signature_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .last_in_frame_i  (last_in_frame_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .detected_o       (detected_o),
    .best_signature_o (best_signature_o),
    .best_x_o         (best_x_o),
    .best_y_o         (best_y_o),
    .best_width_o     (best_width_o),
    .best_height_o    (best_height_o),
    .distance_q4_o    (distance_q4_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    cfg_mirror.sig_a       = lbs_pkg::SIG_A_RESET;
    cfg_mirror.sig_b       = lbs_pkg::SIG_B_RESET;
    cfg_mirror.ref_product = lbs_pkg::REF_RESET;
    best_area              = '0;
    found_blob             = 1'b0;
    kept_blob              = '0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic void track_blob_word(input blob_word_t wd);
    logic [lbs_pkg::AreaW-1:0] area;
    logic [lbs_pkg::RefW-1:0]  quot;
    blob_result_t              res;
    area = {8'd0, wd.box_width} * {9'd0, wd.box_height};
    if (wd.block_valid && (wd.signature == cfg_mirror.sig_a ||
        wd.signature == cfg_mirror.sig_b) && area > best_area) begin
      best_area  = area;
      found_blob = 1'b1;
      kept_blob  = wd;
    end
    if (wd.last_in_frame) begin
      res          = '0;
      res.distance = lbs_pkg::DIST_SAT;
      if (found_blob) begin
        quot          = cfg_mirror.ref_product / {16'd0, kept_blob.box_height};
        res.detected  = 1'b1;
        res.signature = kept_blob.signature;
        res.x         = kept_blob.pos_x;
        res.y         = kept_blob.pos_y;
        res.width     = kept_blob.box_width;
        res.height    = kept_blob.box_height;
        res.distance  = (quot > lbs_pkg::RefW'(lbs_pkg::DIST_SAT)) ? lbs_pkg::DIST_SAT
                                                                   : quot[lbs_pkg::DistW-1:0];
      end
      expected_blobs.push_back(res);
      best_area  = '0;
      found_blob = 1'b0;
      kept_blob  = '0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left    = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blobs.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want_blob = expected_blobs.pop_front();
        if (detected_o !== want_blob.detected)
          report_mismatch("detected", 32'(detected_o), 32'(want_blob.detected));
        if (best_signature_o !== want_blob.signature)
          report_mismatch("best_signature", 32'(best_signature_o),
                          32'(want_blob.signature));
        if (best_x_o !== want_blob.x)
          report_mismatch("best_x", 32'(best_x_o), 32'(want_blob.x));
        if (best_y_o !== want_blob.y)
          report_mismatch("best_y", 32'(best_y_o), 32'(want_blob.y));
        if (best_width_o !== want_blob.width)
          report_mismatch("best_width", 32'(best_width_o), 32'(want_blob.width));
        if (best_height_o !== want_blob.height)
          report_mismatch("best_height", 32'(best_height_o), 32'(want_blob.height));
        if (distance_q4_o !== want_blob.distance)
          report_mismatch("distance_q4", 32'(distance_q4_o), 32'(want_blob.distance));
      end
    end
  end

  task automatic send_word(input blob_word_t wd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    block_valid_i   <= wd.block_valid;
    signature_i     <= wd.signature;
    pos_x_i         <= wd.pos_x;
    pos_y_i         <= wd.pos_y;
    box_width_i     <= wd.box_width;
    box_height_i    <= wd.box_height;
    last_in_frame_i <= wd.last_in_frame;
    do @(posedge clk_i); while (in_stall_o);
    track_blob_word(wd);
    words_sent++;
  endtask

  task automatic send_blob(input logic bv, input logic [lbs_pkg::SigW-1:0] sig,
                           input logic [lbs_pkg::XW-1:0] x, input logic [lbs_pkg::YW-1:0] y,
                           input logic [lbs_pkg::WW-1:0] w, input logic [lbs_pkg::HW-1:0] h,
                           input logic last);
    blob_word_t wd;
    wd = '{bv, sig, x, y, w, h, last};
    send_word(wd);
  endtask

  task automatic wait_results;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_blobs.size() != 0);
  endtask

  task automatic wait_idle;
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input lbs_pkg::reg_idx_e idx,
                           input logic [lbs_pkg::PdataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lbs_pkg::REG_SIG_A: cfg_mirror.sig_a       = value[lbs_pkg::SigW-1:0];
      lbs_pkg::REG_SIG_B: cfg_mirror.sig_b       = value[lbs_pkg::SigW-1:0];
      lbs_pkg::REG_REF:   cfg_mirror.ref_product = value[lbs_pkg::RefW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [lbs_pkg::SigW-1:0] sig_a,
                           input logic [lbs_pkg::SigW-1:0] sig_b,
                           input logic [lbs_pkg::RefW-1:0] ref_val);
    wait_idle();
    apb_write(lbs_pkg::REG_SIG_A, {16'd0, sig_a});
    apb_write(lbs_pkg::REG_SIG_B, {16'd0, sig_b});
    apb_write(lbs_pkg::REG_REF, {8'd0, ref_val});
  endtask

  function automatic blob_word_t random_word(input blob_word_t prev);
    blob_word_t  wd;
    int unsigned pick;
    pick           = $urandom_range(99);
    wd.block_valid = ($urandom_range(99) < 90);
    wd.signature   = (pick < 40) ? cfg_mirror.sig_a :
                     (pick < 80) ? cfg_mirror.sig_b : lbs_pkg::SigW'($urandom);
    wd.pos_x       = lbs_pkg::XW'($urandom_range(511));
    wd.pos_y       = lbs_pkg::YW'($urandom_range(255));
    pick           = $urandom_range(99);
    wd.box_width   = (pick < 8)  ? '0 :
                     (pick < 30) ? lbs_pkg::WW'($urandom_range(511))
                                 : lbs_pkg::WW'($urandom_range(40, 1));
    pick           = $urandom_range(99);
    wd.box_height  = (pick < 8)  ? '0 :
                     (pick < 30) ? lbs_pkg::HW'($urandom_range(255))
                                 : lbs_pkg::HW'($urandom_range(40, 1));
    if ($urandom_range(99) < 15) begin
      wd.box_width  = prev.box_width;
      wd.box_height = prev.box_height;
    end
    wd.last_in_frame = 1'b0;
    return wd;
  endfunction

  task automatic send_random_frame(input int unsigned max_len);
    blob_word_t  wd;
    int unsigned len;
    wd  = '0;
    len = $urandom_range(max_len, 1);
    for (int unsigned i = 0; i < len; i++) begin
      wd               = random_word(wd);
      wd.last_in_frame = (i == len - 1);
      send_word(wd);
    end
  endtask

  task automatic random_config;
    logic [lbs_pkg::SigW-1:0] sig_a;
    logic [lbs_pkg::SigW-1:0] sig_b;
    logic [lbs_pkg::RefW-1:0] ref_val;
    int unsigned              pick;
    pick    = $urandom_range(99);
    sig_a   = (pick < 15) ? '0 : (pick < 30) ? '1 : lbs_pkg::SigW'($urandom);
    sig_b   = ($urandom_range(99) < 25) ? sig_a : lbs_pkg::SigW'($urandom);
    pick    = $urandom_range(99);
    ref_val = (pick < 10) ? '0 : (pick < 25) ? '1 :
              (pick < 70) ? lbs_pkg::RefW'($urandom_range(50000, 1))
                          : lbs_pkg::RefW'($urandom);
    configure(sig_a, sig_b, ref_val);
  endtask

  task automatic test_default_registers;
    send_blob(1'b0, 16'd1, 9'd5, 8'd5, 9'd9, 8'd9, 1'b1);
    send_blob(1'b1, 16'd1, 9'd100, 8'd50, 9'd10, 8'd10, 1'b0);
    send_blob(1'b1, 16'd2, 9'd200, 8'd60, 9'd20, 8'd5, 1'b0);
    send_blob(1'b1, 16'd3, 9'd300, 8'd70, 9'd200, 8'd200, 1'b0);
    send_blob(1'b0, 16'd2, 9'd400, 8'd80, 9'd300, 8'd200, 1'b1);
  endtask

  task automatic test_candidate_rules;
    send_blob(1'b1, 16'd1, 9'd10, 8'd10, 9'd0, 8'd50, 1'b0);
    send_blob(1'b1, 16'd2, 9'd20, 8'd20, 9'd50, 8'd0, 1'b1);
    send_blob(1'b1, 16'd1, 9'd30, 8'd30, 9'd3, 8'd3, 1'b0);
    send_blob(1'b1, 16'd2, 9'd40, 8'd40, 9'd4, 8'd4, 1'b1);
    send_blob(1'b1, 16'd1, 9'd1, 8'd1, 9'd1, 8'd1, 1'b1);
  endtask

  task automatic test_field_extremes;
    configure('0, '1, '1);
    send_blob(1'b1, 16'd0, 9'd511, 8'd255, 9'd511, 8'd255, 1'b0);
    send_blob(1'b1, 16'hffff, 9'd0, 8'd0, 9'd1, 8'd1, 1'b0);
    send_blob(1'b0, 16'hffff, 9'd511, 8'd255, 9'd511, 8'd255, 1'b1);
    send_blob(1'b1, 16'hffff, 9'd0, 8'd0, 9'd511, 8'd255, 1'b1);
    configure(16'd7, 16'd7, '0);
    send_blob(1'b1, 16'd7, 9'd12, 8'd34, 9'd2, 8'd200, 1'b1);
    configure(16'd7, 16'd7, 24'd3000);
    send_blob(1'b1, 16'd7, 9'd56, 8'd78, 9'd9, 8'd255, 1'b1);
    send_blob(1'b1, 16'd8, 9'd56, 8'd78, 9'd9, 8'd255, 1'b1);
  endtask

  task automatic test_receiver_hold;
    configure(16'd1, 16'd2, 24'd24000);
    hold_request = 300;
    for (int i = 0; i < 4; i++) send_random_frame(3);
  endtask

  task automatic test_sender_pause;
    for (int i = 0; i < 4; i++) begin
      send_random_frame(4);
      wait_results();
    end
  endtask

  task automatic test_random_traffic;
    int unsigned chunk_start;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 18 : 0;
      for (int chunk = 0; chunk < 3; chunk++) begin
        random_config();
        chunk_start = words_sent;
        while (words_sent - chunk_start < ChunkWords) send_random_frame(8);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_registers();
    test_candidate_rules();
    test_field_extremes();
    test_receiver_hold();
    test_sender_pause();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
